>>> hdl/pat_pkg.sv
package pat_pkg;

	localparam int ENTRIES   = 16;
	localparam int ID_BITS   = 32;
	localparam int TIME_BITS = 32;
	localparam int EXP_BITS  = 16;
	localparam int CODE_BITS = 2;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [EXP_BITS-1:0]  EXPIRY_RESET = EXP_BITS'(30);
	localparam logic [CODE_BITS-1:0] CODE_ACTIVE  = CODE_BITS'(1);

	typedef enum logic [1:0] {
		REQ_REPORT = 2'd0,
		REQ_POLL   = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_NONE   = 2'd3
	} req_kind_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [CODE_BITS-1:0] code;
		logic [TIME_BITS-1:0] last;
		logic [TIME_BITS-1:0] since;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		req_kind_t            kind;
		logic [ID_BITS-1:0]   id;
		logic [CODE_BITS-1:0] code;
		logic [TIME_BITS-1:0] now;
	} item_t;

	typedef struct packed {
		logic                 any_active;
		logic                 peer_known;
		logic                 peer_active;
		logic [TIME_BITS-1:0] since_time;
		logic                 dropped;
	} result_t;

endpackage

>>> hdl/peer_activity_table_with_aging.sv
// Table of up to ENTRIES remote peers, keyed by ID, holding activity code, last
// update time and since time in a synchronous RAM (one read port, one write port)
// with per-entry valid flops. Every request (report, poll with aging, query) walks
// the whole table one entry per cycle through the RAM read port. Each item is accepted,
// then ENTRIES entries are read in turn, then the final read data returns, then the
// result is posted and written back. The input is held off
// (in_stall high) while a walk is in progress; a finished result sits in an
// output register so the next item may be taken while it waits. expiry_seconds
// is written through the cfg port (always ready) and resets to 30; write it only
// while the block is idle.
module peer_activity_table_with_aging (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pat_pkg::EXP_BITS-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     req_type,
	input  logic [pat_pkg::ID_BITS-1:0]    peer_id,
	input  logic [pat_pkg::CODE_BITS-1:0]  reported_state,
	input  logic [pat_pkg::TIME_BITS-1:0]  cur_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           any_active,
	output logic                           peer_known,
	output logic                           peer_active,
	output logic [pat_pkg::TIME_BITS-1:0]  since_time,
	output logic                           dropped
);
	import pat_pkg::*;

	logic [EXP_BITS-1:0] expiry_q;
	item_t               item;
	logic                item_ready;
	ram_req_t            ram_req;
	entry_t              ram_rdata;
	logic                res_valid;
	logic                res_ready;
	result_t             res;
	logic                out_valid_q;
	result_t             out_res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= EXPIRY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			expiry_q <= cfg_data;
		end
	end

	assign item.kind = req_kind_t'(req_type);
	assign item.id   = peer_id;
	assign item.code = reported_state;
	assign item.now  = cur_time;
	assign in_stall  = !item_ready;

	pat_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	pat_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (in_valid),
		.item_ready (item_ready),
		.item       (item),
		.expiry     (expiry_q),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register, reloaded in the cycle its transfer completes
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign any_active  = out_res_q.any_active;
	assign peer_known  = out_res_q.peer_known;
	assign peer_active = out_res_q.peer_active;
	assign since_time  = out_res_q.since_time;
	assign dropped     = out_res_q.dropped;

endmodule

>>> hdl/pat_ram.sv
module pat_ram (
	input  logic              clk,
	input  pat_pkg::ram_req_t req,
	output pat_pkg::entry_t   rdata
);
	import pat_pkg::*;

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

>>> hdl/pat_walk.sv
module pat_walk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  pat_pkg::item_t                 item,
	input  logic [pat_pkg::EXP_BITS-1:0]   expiry,
	output pat_pkg::ram_req_t              ram_req,
	input  pat_pkg::entry_t                ram_rdata,
	output logic                           res_valid,
	input  logic                           res_ready,
	output pat_pkg::result_t               res
);
	import pat_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t               state_q;
	item_t                item_q;
	logic [IDX_W-1:0]     rd_cnt_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [ENTRIES-1:0]   valid_q;
	logic                 found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic [CODE_BITS-1:0] match_code_q;
	logic [TIME_BITS-1:0] match_since_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 any_q;

	logic                 cur_valid;
	logic                 hit;
	logic                 free;
	logic [TIME_BITS:0]   deadline;
	logic                 expired;
	logic                 finish;
	logic                 insert;

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_FINISH);
	assign finish     = res_valid && res_ready;

	assign cur_valid = valid_q[idx_s1];
	assign hit       = vld_s1 && cur_valid && (ram_rdata.id == item_q.id);
	assign free      = vld_s1 && !cur_valid;
	// last update + expiry, one bit wider so the sum cannot wrap
	assign deadline  = {1'b0, ram_rdata.last} + (TIME_BITS+1)'(expiry);
	assign expired   = ({1'b0, item_q.now} > deadline);

	assign insert = finish && (item_q.kind == REQ_REPORT) && !found_q && free_found_q;

	always_comb begin
		ram_req.re          = (state_q == ST_SCAN);
		ram_req.raddr       = rd_cnt_q;
		ram_req.we          = finish && (item_q.kind == REQ_REPORT) && (found_q || free_found_q);
		ram_req.waddr       = found_q ? match_idx_q : free_idx_q;
		ram_req.wdata.id    = item_q.id;
		ram_req.wdata.code  = item_q.code;
		ram_req.wdata.last  = item_q.now;
		ram_req.wdata.since = (found_q && (match_code_q == item_q.code)) ?
		                      match_since_q : item_q.now;
	end

	always_comb begin
		res = '0;
		case (item_q.kind)
			REQ_REPORT: begin
				res.dropped = !found_q && !free_found_q;
			end
			REQ_POLL: begin
				res.any_active = any_q;
			end
			REQ_QUERY: begin
				res.peer_known  = found_q;
				res.peer_active = found_q && (match_code_q == CODE_ACTIVE);
				res.since_time  = found_q ? match_since_q : '0;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_cnt_q     <= '0;
			vld_s1       <= 1'b0;
			valid_q      <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			any_q        <= 1'b0;
		end else begin
			vld_s1 <= ram_req.re;
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q      <= ST_SCAN;
						rd_cnt_q     <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						any_q        <= 1'b0;
					end
				end
				ST_SCAN: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// lowest-numbered match and free slot win
			if (hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (free && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (vld_s1 && (item_q.kind == REQ_POLL) && cur_valid) begin
				if (expired) begin
					valid_q[idx_s1] <= 1'b0;
				end else if (ram_rdata.code == CODE_ACTIVE) begin
					any_q <= 1'b1;
				end
			end
			if (insert) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q;
		if (item_ready && item_valid) begin
			item_q <= item;
		end
		if (hit && !found_q) begin
			match_idx_q   <= idx_s1;
			match_code_q  <= ram_rdata.code;
			match_since_q <= ram_rdata.since;
		end
		if (free && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

endmodule
